FILE: sv/ptl_pkg.sv
// Shared constants, types and helpers for the pedestrian traffic light.
`timescale 1ns / 1ps
package ptl_pkg;

	localparam int TIMER_BITS = 16;
	// Width wide enough for both the 16-bit length registers and the phase timer
	localparam int CMP_BITS = (TIMER_BITS > 16) ? TIMER_BITS : 16;
	localparam logic [CMP_BITS-1:0] TIMER_MAX = CMP_BITS'((64'd1 << TIMER_BITS) - 64'd1);

	localparam logic [1:0] PH_RED    = 2'd0;
	localparam logic [1:0] PH_GREEN  = 2'd1;
	localparam logic [1:0] PH_YELLOW = 2'd2;

	localparam logic [1:0] REG_MAIN_PHASE   = 2'd0;
	localparam logic [1:0] REG_YELLOW_PHASE = 2'd1;
	localparam logic [1:0] REG_BEEP_ON      = 2'd2;
	localparam logic [1:0] REG_BEEP_GAP     = 2'd3;

	localparam logic [15:0] MAIN_PHASE_RST   = 16'd10000;
	localparam logic [15:0] YELLOW_PHASE_RST = 16'd3000;
	localparam logic [7:0]  BEEP_ON_RST      = 8'd100;
	localparam logic [7:0]  BEEP_GAP_RST     = 8'd20;

	localparam logic [1:0] BEEPS_RED    = 2'd3;
	localparam logic [1:0] BEEPS_YELLOW = 2'd2;
	localparam logic [1:0] BEEPS_GREEN  = 2'd1;

	localparam int CD_START = 5000;
	localparam int CD_STEP  = 1000;
	localparam int CD_END   = 9000;
	localparam int CD_FIRST = 5;

	typedef struct packed {
		logic [15:0] main_phase_ms;
		logic [15:0] yellow_phase_ms;
		logic [7:0]  beep_on_ms;
		logic [7:0]  beep_gap_ms;
	} cfg_t;

	typedef struct packed {
		logic [1:0] phase_code;
		logic [2:0] countdown_shown;
		logic       buzzer_on;
		logic       green_lamp;
		logic       red_lamp;
	} result_t;

	// Force a phase length into 1 .. TIMER_MAX
	function automatic logic [CMP_BITS-1:0] clip_len(input logic [CMP_BITS-1:0] v);
		logic [CMP_BITS-1:0] r;
		r = v;
		if (r == '0) begin
			r = CMP_BITS'(1);
		end
		if (r > TIMER_MAX) begin
			r = TIMER_MAX;
		end
		return r;
	endfunction

endpackage

FILE: sv/ptl_cfg.sv
// Configuration register file of the pedestrian traffic light.
`timescale 1ns / 1ps
module ptl_cfg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [15:0]    cfg_data,
	output ptl_pkg::cfg_t  cfg
);

	ptl_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.main_phase_ms   <= ptl_pkg::MAIN_PHASE_RST;
			cfg_q.yellow_phase_ms <= ptl_pkg::YELLOW_PHASE_RST;
			cfg_q.beep_on_ms      <= ptl_pkg::BEEP_ON_RST;
			cfg_q.beep_gap_ms     <= ptl_pkg::BEEP_GAP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ptl_pkg::REG_MAIN_PHASE:   cfg_q.main_phase_ms   <= cfg_data;
				ptl_pkg::REG_YELLOW_PHASE: cfg_q.yellow_phase_ms <= cfg_data;
				ptl_pkg::REG_BEEP_ON:      cfg_q.beep_on_ms      <= cfg_data[7:0];
				ptl_pkg::REG_BEEP_GAP:     cfg_q.beep_gap_ms     <= cfg_data[7:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: sv/ptl_core.sv
// Phase, buzzer and countdown state with its one-step update.
`timescale 1ns / 1ps
module ptl_core (
	input  logic              clk,
	input  logic              arst_n,
	input  ptl_pkg::cfg_t     cfg,
	input  logic              step,
	input  logic              tick,
	input  logic              press,
	output ptl_pkg::result_t  result
);

	logic [1:0]                     phase_q, phase_n, phase_c;
	logic                           lock_q, lock_n;
	logic [ptl_pkg::TIMER_BITS-1:0] timer_q, timer_n, timer_inc;
	logic [1:0]                     beeps_q, beeps_n;
	logic [7:0]                     bt_q, bt_n, bt_inc;
	logic                           buzz_q, buzz_n;
	logic [2:0]                     cd_q, cd_n;
	logic [ptl_pkg::CMP_BITS-1:0]   t_ext, red_len;
	logic [7:0]                     on_eff, gap_eff;
	logic                           enter;
	logic [1:0]                     enter_ph, enter_beeps;

	assign phase_c = (phase_q == ptl_pkg::PH_GREEN || phase_q == ptl_pkg::PH_YELLOW)
		? phase_q : ptl_pkg::PH_RED;
	assign timer_inc = (ptl_pkg::CMP_BITS'(timer_q) < ptl_pkg::TIMER_MAX)
		? timer_q + 1'b1 : timer_q;
	assign t_ext   = ptl_pkg::CMP_BITS'(timer_inc);
	assign bt_inc  = bt_q + 8'd1;
	assign on_eff  = (cfg.beep_on_ms == '0) ? 8'd1 : cfg.beep_on_ms;
	assign gap_eff = (cfg.beep_gap_ms == '0) ? 8'd1 : cfg.beep_gap_ms;
	// Red after a request lasts at least until the last countdown step
	assign red_len = (lock_q && cfg.main_phase_ms < 16'(ptl_pkg::CD_END))
		? ptl_pkg::CMP_BITS'(ptl_pkg::CD_END) : ptl_pkg::CMP_BITS'(cfg.main_phase_ms);

	always_comb begin
		phase_n     = phase_c;
		lock_n      = lock_q;
		timer_n     = timer_q;
		beeps_n     = beeps_q;
		bt_n        = bt_q;
		buzz_n      = buzz_q;
		cd_n        = cd_q;
		enter       = 1'b0;
		enter_ph    = ptl_pkg::PH_YELLOW;
		enter_beeps = ptl_pkg::BEEPS_YELLOW;
		if (press && !lock_q) begin
			lock_n = 1'b1;
			enter  = 1'b1;
		end else if (tick) begin
			if (beeps_q != 2'd0) begin
				bt_n = bt_inc;
				if (buzz_q) begin
					if (bt_inc >= on_eff) begin
						buzz_n  = 1'b0;
						bt_n    = 8'd0;
						beeps_n = beeps_q - 2'd1;
					end
				end else if (bt_inc >= gap_eff) begin
					buzz_n = 1'b1;
					bt_n   = 8'd0;
				end
			end
			timer_n = timer_inc;
			case (phase_c)
				ptl_pkg::PH_GREEN: begin
					if (t_ext >= ptl_pkg::clip_len(ptl_pkg::CMP_BITS'(cfg.main_phase_ms))) begin
						enter = 1'b1;
					end
				end
				ptl_pkg::PH_YELLOW: begin
					if (t_ext >= ptl_pkg::clip_len(ptl_pkg::CMP_BITS'(cfg.yellow_phase_ms))) begin
						enter       = 1'b1;
						enter_ph    = ptl_pkg::PH_RED;
						enter_beeps = ptl_pkg::BEEPS_RED;
					end
				end
				default: begin
					// Countdown shows 5..1 on whole seconds from 5 s into red
					for (int k = 0; k < ptl_pkg::CD_FIRST; k++) begin
						if (lock_q && t_ext == ptl_pkg::CMP_BITS'(ptl_pkg::CD_START
							+ k * ptl_pkg::CD_STEP)) begin
							cd_n = 3'(ptl_pkg::CD_FIRST - k);
						end
					end
					if (t_ext >= ptl_pkg::clip_len(red_len)) begin
						lock_n      = 1'b0;
						enter       = 1'b1;
						enter_ph    = ptl_pkg::PH_GREEN;
						enter_beeps = ptl_pkg::BEEPS_GREEN;
					end
				end
			endcase
		end
		if (enter) begin
			phase_n = enter_ph;
			timer_n = '0;
			beeps_n = enter_beeps;
			bt_n    = 8'd0;
			buzz_n  = 1'b1;
			cd_n    = 3'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ptl_pkg::PH_RED;
			lock_q  <= 1'b0;
			timer_q <= '0;
			beeps_q <= ptl_pkg::BEEPS_RED;
			bt_q    <= 8'd0;
			buzz_q  <= 1'b1;
			cd_q    <= 3'd0;
		end else if (step) begin
			phase_q <= phase_n;
			lock_q  <= lock_n;
			timer_q <= timer_n;
			beeps_q <= beeps_n;
			bt_q    <= bt_n;
			buzz_q  <= buzz_n;
			cd_q    <= cd_n;
		end
	end

	assign result.red_lamp        = (phase_n == ptl_pkg::PH_RED || phase_n == ptl_pkg::PH_YELLOW);
	assign result.green_lamp      = (phase_n == ptl_pkg::PH_GREEN
		|| phase_n == ptl_pkg::PH_YELLOW);
	assign result.buzzer_on       = (beeps_n != 2'd0) && buzz_n;
	assign result.countdown_shown = (phase_n == ptl_pkg::PH_RED) ? cd_n : 3'd0;
	assign result.phase_code      = phase_n;

	a_green_unlocked: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == ptl_pkg::PH_GREEN |-> !lock_q)
		else $error("request lock set during green");

	a_cd_needs_lock: assert property (@(posedge clk) disable iff (!arst_n)
		cd_q != 3'd0 |-> lock_q && phase_q == ptl_pkg::PH_RED)
		else $error("countdown outside a requested red");

	a_cd_range: assert property (@(posedge clk) disable iff (!arst_n)
		cd_q <= 3'(ptl_pkg::CD_FIRST))
		else $error("countdown out of range");

	a_buzz_done: assert property (@(posedge clk) disable iff (!arst_n)
		beeps_q == 2'd0 |-> !buzz_q)
		else $error("buzzer sounding with no beeps left");

endmodule

FILE: sv/pedestrian_traffic_light.sv
// Top level of the pedestrian traffic light: input stage, state update, result stage.
//
//  channel   dir  payload                                             handshake
//  s_axis    in   tdata[0] tick, [1] pedestrian_press, [7:2] zero     s_tvalid/s_tready
//  m_axis    out  tdata[0] red, [1] green, [2] buzzer, [5:3] cd, [7:6] phase
//                                                                     m_tvalid/m_tready
//  cfg       in   cfg_index selects register, cfg_data value          cfg_we
//
// One request per cycle sustained while m_tready is high; a request's result passes through s1 and s2 to m_tdata.
// The state update is a single pass of counters and compares between the s1 and s2 registers.
// Reset clears the core state to red with the three-beep pattern and loads default register values.
// A stalled output holds s2; s1 then holds too and s_tready drops only when both are full.
`timescale 1ns / 1ps
module pedestrian_traffic_light (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] tick, [1] pedestrian_press, [7:2] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] red_lamp, [1] green_lamp, [2] buzzer_on,
	                               // [5:3] countdown_shown, [7:6] phase_code
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	ptl_pkg::cfg_t    cfg;
	ptl_pkg::result_t result;
	logic             valid_s1, tick_s1, press_s1;
	logic             valid_s2;
	ptl_pkg::result_t res_s2;
	logic             adv_s2, step;

	assign adv_s2   = !valid_s2 || m_tready;
	assign step     = valid_s1 && adv_s2;
	assign s_tready = !valid_s1 || adv_s2;

	ptl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ptl_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (step),
		.tick   (tick_s1),
		.press  (press_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			tick_s1  <= s_tdata[0];
			press_s1 <= s_tdata[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = res_s2;

endmodule

FILE: tb/sv/tb_top.sv
// Testbench for the pedestrian traffic light: predicts the lamp outputs and checks them.
`timescale 1ns / 1ps
module tb_top;

	localparam int unsigned CYCLE_LIMIT = 2_000_000;

	// Tracks lamp, buzzer and countdown state; holds the lamp results still owed by the block
	class light_checker;
		logic [15:0]      main_len;
		logic [15:0]      yellow_len;
		logic [7:0]       beep_on;
		logic [7:0]       beep_gap;
		logic [1:0]       phase;
		bit               lock;
		longint unsigned  phase_timer;
		logic [1:0]       beeps_left;
		logic [7:0]       beep_timer;
		bit               buzzing;
		logic [2:0]       countdown;
		ptl_pkg::result_t expected_lamps[$];
		int               errors;

		function new();
			main_len = ptl_pkg::MAIN_PHASE_RST;
			yellow_len = ptl_pkg::YELLOW_PHASE_RST;
			beep_on = ptl_pkg::BEEP_ON_RST;
			beep_gap = ptl_pkg::BEEP_GAP_RST;
			lock = 1'b0;
			errors = 0;
			start_phase(ptl_pkg::PH_RED, ptl_pkg::BEEPS_RED);
		endfunction

		function void set_reg(logic [1:0] idx, logic [15:0] val);
			case (idx)
				ptl_pkg::REG_MAIN_PHASE:   main_len = val;
				ptl_pkg::REG_YELLOW_PHASE: yellow_len = val;
				ptl_pkg::REG_BEEP_ON:      beep_on = val[7:0];
				ptl_pkg::REG_BEEP_GAP:     beep_gap = val[7:0];
				default: ;
			endcase
		endfunction

		function void start_phase(logic [1:0] p, logic [1:0] beeps);
			phase = p;
			phase_timer = 0;
			beeps_left = beeps;
			beep_timer = 8'd0;
			buzzing = 1'b1;
			countdown = 3'd0;
		endfunction

		// Zero acts as one; lengths beyond the timer end when the timer saturates
		function longint unsigned span(longint unsigned v);
			longint unsigned tmax;
			tmax = (64'd1 << ptl_pkg::TIMER_BITS) - 1;
			if (v == 0) begin
				v = 1;
			end
			return (v > tmax) ? tmax : v;
		endfunction

		function void step_buzzer();
			logic [7:0] on_len;
			logic [7:0] gap_len;
			on_len = (beep_on == 8'd0) ? 8'd1 : beep_on;
			gap_len = (beep_gap == 8'd0) ? 8'd1 : beep_gap;
			if (beeps_left == 2'd0) begin
				return;
			end
			beep_timer = beep_timer + 8'd1;
			if (buzzing) begin
				if (beep_timer >= on_len) begin
					buzzing = 1'b0;
					beep_timer = 8'd0;
					beeps_left = beeps_left - 2'd1;
				end
			end else if (beep_timer >= gap_len) begin
				buzzing = 1'b1;
				beep_timer = 8'd0;
			end
		endfunction

		function void step_phase();
			longint unsigned tmax;
			longint unsigned red_len;
			tmax = (64'd1 << ptl_pkg::TIMER_BITS) - 1;
			if (phase_timer < tmax) begin
				phase_timer++;
			end
			case (phase)
				ptl_pkg::PH_GREEN: begin
					if (phase_timer >= span(main_len)) begin
						start_phase(ptl_pkg::PH_YELLOW, ptl_pkg::BEEPS_YELLOW);
					end
				end
				ptl_pkg::PH_YELLOW: begin
					if (phase_timer >= span(yellow_len)) begin
						start_phase(ptl_pkg::PH_RED, ptl_pkg::BEEPS_RED);
					end
				end
				default: begin
					if (lock && phase_timer >= ptl_pkg::CD_START
							&& phase_timer <= ptl_pkg::CD_END
							&& (phase_timer - ptl_pkg::CD_START) % ptl_pkg::CD_STEP == 0) begin
						countdown = 3'(ptl_pkg::CD_FIRST
							- (phase_timer - ptl_pkg::CD_START) / ptl_pkg::CD_STEP);
					end
					// Red after a request lasts at least until the countdown reached one
					red_len = main_len;
					if (lock && red_len < ptl_pkg::CD_END) begin
						red_len = ptl_pkg::CD_END;
					end
					if (phase_timer >= span(red_len)) begin
						lock = 1'b0;
						start_phase(ptl_pkg::PH_GREEN, ptl_pkg::BEEPS_GREEN);
					end
				end
			endcase
		endfunction

		function void take_request(bit tick, bit press);
			ptl_pkg::result_t r;
			// An accepted press absorbs the tick of the same request
			if (press && !lock) begin
				lock = 1'b1;
				start_phase(ptl_pkg::PH_YELLOW, ptl_pkg::BEEPS_YELLOW);
			end else if (tick) begin
				step_buzzer();
				step_phase();
			end
			r.red_lamp = (phase == ptl_pkg::PH_RED || phase == ptl_pkg::PH_YELLOW);
			r.green_lamp = (phase == ptl_pkg::PH_GREEN || phase == ptl_pkg::PH_YELLOW);
			r.buzzer_on = (beeps_left != 2'd0) && buzzing;
			r.countdown_shown = (phase == ptl_pkg::PH_RED) ? countdown : 3'd0;
			r.phase_code = phase;
			expected_lamps.push_back(r);
		endfunction

		function void check_lamps(ptl_pkg::result_t got);
			ptl_pkg::result_t want;
			if (expected_lamps.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			want = expected_lamps.pop_front();
			if (got.red_lamp !== want.red_lamp) begin
				$display("%0t: red_lamp expected %0d, got %0d", $time, want.red_lamp,
					got.red_lamp);
				errors++;
			end
			if (got.green_lamp !== want.green_lamp) begin
				$display("%0t: green_lamp expected %0d, got %0d", $time, want.green_lamp,
					got.green_lamp);
				errors++;
			end
			if (got.buzzer_on !== want.buzzer_on) begin
				$display("%0t: buzzer_on expected %0d, got %0d", $time, want.buzzer_on,
					got.buzzer_on);
				errors++;
			end
			if (got.countdown_shown !== want.countdown_shown) begin
				$display("%0t: countdown_shown expected %0d, got %0d", $time,
					want.countdown_shown, got.countdown_shown);
				errors++;
			end
			if (got.phase_code !== want.phase_code) begin
				$display("%0t: phase_code expected %0d, got %0d", $time, want.phase_code,
					got.phase_code);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;   // [0] tick, [1] pedestrian_press, [7:2] zero
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;          // [0] red_lamp, [1] green_lamp, [2] buzzer_on,
	                               // [5:3] countdown_shown, [7:6] phase_code
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = 2'd0;
	logic [15:0] cfg_data = 16'd0;

	bit           steady = 1'b0;
	int unsigned  cycles = 0;
	light_checker lights = new();

	pedestrian_traffic_light dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout", $time);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= 16);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			lights.check_lamps(ptl_pkg::result_t'(m_tdata));
		end
	end

	task automatic send(bit tick, bit press);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 16) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, press, tick};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		lights.take_request(tick, press);
	endtask

	// Drop valid and wait until every lamp result has come back
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (lights.expected_lamps.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(logic [1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		lights.set_reg(idx, val);
	endtask

	task automatic apply_cfg(input logic [15:0] main_v, input logic [15:0] yellow_v,
			input logic [7:0] on_v, input logic [7:0] gap_v);
		drain();
		put_reg(ptl_pkg::REG_MAIN_PHASE, main_v);
		put_reg(ptl_pkg::REG_YELLOW_PHASE, yellow_v);
		put_reg(ptl_pkg::REG_BEEP_ON, {8'd0, on_v});
		put_reg(ptl_pkg::REG_BEEP_GAP, {8'd0, gap_v});
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// While a request holds the lock, run mostly ticks through yellow and the countdown red;
	// presses there are refused. Otherwise send mostly ticks, with up to quota presses at pct percent.
	task automatic run_random(int n, int quota, int pct);
		int  counted;
		int  presses_left;
		bit  tick;
		bit  press;
		counted = 0;
		presses_left = quota;
		while (counted < n) begin
			if (lights.lock) begin
				tick = ($urandom_range(0, 19) != 0);
				press = ($urandom_range(0, 9) == 0);
			end else begin
				tick = ($urandom_range(0, 3) != 0);
				press = (presses_left > 0) && ($urandom_range(0, 99) < pct);
				if (press) begin
					presses_left--;
				end
			end
			counted++;
			send(tick, press);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset values: plain items in the first red
		send(1'b0, 1'b0);
		send(1'b1, 1'b0);
		send(1'b1, 1'b0);
		// No idling on either side
		steady = 1'b1;
		run_random(60, 0, 0);
		steady = 1'b0;

		// Shortest lengths: one-tick phases
		apply_cfg(16'd1, 16'd1, 8'd1, 8'd1);
		run_random(120, 0, 0);

		apply_cfg(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
		run_random(40, 0, 0);

		// Zero lengths act as one
		apply_cfg(16'd0, 16'd0, 8'd0, 8'd0);
		run_random(60, 0, 0);

		apply_cfg(16'($urandom_range(20, 300)), 16'($urandom_range(5, 100)),
			8'($urandom_range(1, 20)), 8'($urandom_range(1, 20)));
		run_random(150, 1, 2);
		// Take the lock if still clear, then a refused press, then run in the locked phases
		send(1'b1, 1'b1);
		send(1'b0, 1'b1);
		run_random(160, 0, 0);

		drain();
		if (lights.errors == 0 && lights.expected_lamps.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

FILE: filelist.f
sv/ptl_pkg.sv
sv/ptl_cfg.sv
sv/ptl_core.sv
sv/pedestrian_traffic_light.sv
tb/sv/tb_top.sv
